/* rtl/cbp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbp_pkg
// Shared types and constants for the covalent bond perception block.
// ----------------------------------------------------------------------------
package cbp_pkg;

    localparam int MAX_ATOMS_DEF = 64;
    localparam int COORD_W       = 20;
    localparam int RAD_W         = 12;
    localparam int TOL_W         = 12;
    localparam int IDX_W         = 6;
    localparam int MAX_RESULTS   = 63;
    localparam int BCNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int DIFF_W        = COORD_W + 1;
    localparam int LIM_W         = RAD_W + 2;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int ACC_W         = PROD_W;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(461);

    // APB register map
    localparam int          APB_AW   = 3;
    localparam logic        REG_TOL  = 1'b0;   // word index of bond_tolerance

    typedef struct packed {
        logic [RAD_W-1:0]          r;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } atom_t;

    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_Z,
        SEL_LIM
    } mul_sel_t;

    typedef struct packed {
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     acc_add;
    } dp_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_Z,
        ST_MUL_LIM,
        ST_CMP,
        ST_FINISH,
        ST_OVF
    } state_t;

endpackage
`default_nettype wire

/* rtl/cbp_atom_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbp_atom_mem
// Atom store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cbp_atom_mem #(
    parameter int DEPTH = cbp_pkg::MAX_ATOMS_DEF,
    parameter int WIDTH = $bits(cbp_pkg::atom_t)
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/cbp_dist_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbp_dist_unit
// Shared multiplier with accumulator: builds the squared distance over three
// passes, squares the bond limit on a fourth, then compares.
// ----------------------------------------------------------------------------
module cbp_dist_unit (
    input  wire logic                            clk,
    input  wire cbp_pkg::dp_ctrl_t               ctrl,
    input  wire cbp_pkg::atom_t                  new_atom,
    input  wire cbp_pkg::atom_t                  old_atom,
    input  wire logic [cbp_pkg::TOL_W-1:0]       tol,
    output logic                                 in_reach
);

    localparam int DW = cbp_pkg::DIFF_W;
    localparam int CW = cbp_pkg::COORD_W;
    localparam int LW = cbp_pkg::LIM_W;

    logic signed [CW-1:0]          a_coord;
    logic signed [CW-1:0]          b_coord;
    logic signed [DW-1:0]          diff;
    logic [DW-1:0]                 mag;
    logic [LW-1:0]                 lim;
    logic [DW-1:0]                 mul_op;
    logic [cbp_pkg::PROD_W-1:0]    prod_reg;
    logic [cbp_pkg::ACC_W-1:0]     acc_reg;

    always_comb
    begin
        case (ctrl.mul_sel)
            cbp_pkg::SEL_X:
            begin
                a_coord = new_atom.x;
                b_coord = old_atom.x;
            end
            cbp_pkg::SEL_Y:
            begin
                a_coord = new_atom.y;
                b_coord = old_atom.y;
            end
            default:
            begin
                a_coord = new_atom.z;
                b_coord = old_atom.z;
            end
        endcase
    end

    assign diff = DW'(a_coord) - DW'(b_coord);
    assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
    assign lim  = LW'(new_atom.r) + LW'(old_atom.r) + LW'(tol);

    assign mul_op = (ctrl.mul_sel == cbp_pkg::SEL_LIM) ? DW'(lim) : mag;

    // product of pass k is folded into the sum during pass k+1
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= mul_op * mul_op;
        end
        if (ctrl.acc_load)
        begin
            acc_reg <= prod_reg;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign in_reach = (acc_reg <= prod_reg);

endmodule
`default_nettype wire

/* rtl/cbp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbp_ctrl
// Sequencer: walks the stored atoms, drives the shared unit, holds one bond
// back so the last one can be marked, and owns the result register.
// ----------------------------------------------------------------------------
module cbp_ctrl #(
    parameter int MAX_ATOMS = cbp_pkg::MAX_ATOMS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_start,
    input  wire logic                          in_reach,
    output cbp_pkg::dp_ctrl_t                  dp_ctrl,
    output logic                               mem_we,
    output logic [$clog2(MAX_ATOMS)-1:0]       mem_waddr,
    output logic                               mem_re,
    output logic [$clog2(MAX_ATOMS)-1:0]       mem_raddr,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cbp_pkg::IDX_W-1:0]          out_earlier,
    output logic [cbp_pkg::IDX_W-1:0]          out_new,
    output logic                               out_bonded,
    output logic                               out_overflow,
    output logic                               out_last
);

    localparam int AW = $clog2(MAX_ATOMS);
    localparam int CW = $clog2(MAX_ATOMS + 1);
    localparam int IW = cbp_pkg::IDX_W;
    localparam int BW = cbp_pkg::BCNT_W;

    cbp_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   i_reg, i_next;
    logic [BW-1:0]   bcnt_reg, bcnt_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [AW-1:0]   pend_e_reg, pend_e_next;
    logic            out_valid_reg, out_valid_next;
    logic [IW-1:0]   out_e_reg, out_e_next;
    logic [IW-1:0]   out_n_reg, out_n_next;
    logic            out_b_reg, out_b_next;
    logic            out_o_reg, out_o_next;
    logic            out_l_reg, out_l_next;

    logic [CW-1:0]   eff_count;
    logic            out_free;
    logic            hit;

    assign eff_count = in_start ? '0 : count_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign hit       = in_reach && (bcnt_reg < BW'(cbp_pkg::MAX_RESULTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cbp_pkg::ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            i_reg          <= '0;
            bcnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            i_reg          <= i_next;
            bcnt_reg       <= bcnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_e_reg <= pend_e_next;
        out_e_reg  <= out_e_next;
        out_n_reg  <= out_n_next;
        out_b_reg  <= out_b_next;
        out_o_reg  <= out_o_next;
        out_l_reg  <= out_l_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        i_next          = i_reg;
        bcnt_next       = bcnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_e_next     = pend_e_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_e_next      = out_e_reg;
        out_n_next      = out_n_reg;
        out_b_next      = out_b_reg;
        out_o_next      = out_o_reg;
        out_l_next      = out_l_reg;
        in_ready        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = eff_count[AW-1:0];
        mem_re          = 1'b0;
        mem_raddr       = i_reg;
        dp_ctrl         = '0;
        dp_ctrl.mul_sel = cbp_pkg::SEL_X;

        case (state_reg)
            cbp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    count_next = eff_count;
                    if (eff_count >= CW'(MAX_ATOMS))
                    begin
                        state_next = cbp_pkg::ST_OVF;
                    end
                    else
                    begin
                        // new atom goes in now; the walk only reads below it
                        mem_we          = 1'b1;
                        idx_next        = eff_count[AW-1:0];
                        count_next      = eff_count + 1'b1;
                        i_next          = '0;
                        bcnt_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = (eff_count == '0) ? cbp_pkg::ST_FINISH
                                                            : cbp_pkg::ST_READ;
                    end
                end
            end
            cbp_pkg::ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = cbp_pkg::ST_MUL_X;
            end
            cbp_pkg::ST_MUL_X:
            begin
                dp_ctrl.mul_en  = 1'b1;
                dp_ctrl.mul_sel = cbp_pkg::SEL_X;
                state_next      = cbp_pkg::ST_MUL_Y;
            end
            cbp_pkg::ST_MUL_Y:
            begin
                dp_ctrl.mul_en   = 1'b1;
                dp_ctrl.mul_sel  = cbp_pkg::SEL_Y;
                dp_ctrl.acc_load = 1'b1;
                state_next       = cbp_pkg::ST_MUL_Z;
            end
            cbp_pkg::ST_MUL_Z:
            begin
                dp_ctrl.mul_en  = 1'b1;
                dp_ctrl.mul_sel = cbp_pkg::SEL_Z;
                dp_ctrl.acc_add = 1'b1;
                state_next      = cbp_pkg::ST_MUL_LIM;
            end
            cbp_pkg::ST_MUL_LIM:
            begin
                dp_ctrl.mul_en  = 1'b1;
                dp_ctrl.mul_sel = cbp_pkg::SEL_LIM;
                dp_ctrl.acc_add = 1'b1;
                state_next      = cbp_pkg::ST_CMP;
            end
            cbp_pkg::ST_CMP:
            begin
                // a second bond pushes the held one out; wait if that's blocked
                if (!(hit && pend_valid_reg && !out_free))
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_e_next     = IW'(pend_e_reg);
                            out_n_next     = IW'(idx_reg);
                            out_b_next     = 1'b1;
                            out_o_next     = 1'b0;
                            out_l_next     = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_e_next     = i_reg;
                        bcnt_next       = bcnt_reg + 1'b1;
                    end
                    i_next     = AW'(i_reg + 1'b1);
                    state_next = (AW'(i_reg + 1'b1) == idx_reg) ? cbp_pkg::ST_FINISH
                                                                : cbp_pkg::ST_READ;
                end
            end
            cbp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_e_next     = pend_valid_reg ? IW'(pend_e_reg) : '0;
                    out_n_next     = IW'(idx_reg);
                    out_b_next     = pend_valid_reg;
                    out_o_next     = 1'b0;
                    out_l_next     = 1'b1;
                    state_next     = cbp_pkg::ST_IDLE;
                end
            end
            cbp_pkg::ST_OVF:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_e_next     = '0;
                    out_n_next     = '0;
                    out_b_next     = 1'b0;
                    out_o_next     = 1'b1;
                    out_l_next     = 1'b1;
                    state_next     = cbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cbp_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign out_earlier  = out_e_reg;
    assign out_new      = out_n_reg;
    assign out_bonded   = out_b_reg;
    assign out_overflow = out_o_reg;
    assign out_last     = out_l_reg;

endmodule
`default_nettype wire

/* rtl/covalent_bond_perception.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// covalent_bond_perception
// Streams atoms in, reports bonded pairs against the earlier atoms of the
// current molecule.
// ----------------------------------------------------------------------------
// Each accepted atom is compared with every stored atom of the molecule, in
// ascending index order, using one shared 21x21 multiplier: a stored atom goes
// through memory read, dx^2, dy^2, dz^2, limit^2 and compare, in that order,
// and s_tready stays low until the atom's last result is registered, which any
// result-side stall delays. A start request clears
// the molecule; atoms beyond MAX_ATOMS produce a single overflow result. The
// bond limit is r_new + r_old + bond_tolerance (APB address 0, reset 461).
// ----------------------------------------------------------------------------
module covalent_bond_perception #(
    parameter int MAX_ATOMS = cbp_pkg::MAX_ATOMS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // APB
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cbp_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    // atom stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [71:0]                 s_tdata,  // coord_x, coord_y, coord_z, atom_radius
    input  wire logic                        s_tuser,  // start_molecule
    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [15:0]                      m_tdata,  // earlier_index, new_index, 4'b0
    output logic [1:0]                       m_tuser,  // bonded, overflow
    output logic                             m_tlast   // last_result
);

    localparam int AW = $clog2(MAX_ATOMS);
    localparam int IW = cbp_pkg::IDX_W;

    logic [cbp_pkg::TOL_W-1:0] tol_reg;
    cbp_pkg::atom_t            in_atom;
    cbp_pkg::atom_t            atom_reg;
    cbp_pkg::atom_t            old_atom;
    cbp_pkg::dp_ctrl_t         dp_ctrl;
    logic                      in_reach;
    logic                      mem_we;
    logic                      mem_re;
    logic [AW-1:0]             mem_waddr;
    logic [AW-1:0]             mem_raddr;
    logic [IW-1:0]             out_earlier;
    logic [IW-1:0]             out_new;
    logic                      out_bonded;
    logic                      out_overflow;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == cbp_pkg::REG_TOL) ? 32'(tol_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= cbp_pkg::TOL_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == cbp_pkg::REG_TOL))
        begin
            tol_reg <= pwdata[cbp_pkg::TOL_W-1:0];
        end
    end

    assign in_atom.x = s_tdata[19:0];
    assign in_atom.y = s_tdata[39:20];
    assign in_atom.z = s_tdata[59:40];
    assign in_atom.r = s_tdata[71:60];

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            atom_reg <= in_atom;
        end
    end

    cbp_atom_mem #(
        .DEPTH (MAX_ATOMS),
        .WIDTH ($bits(cbp_pkg::atom_t))
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (in_atom),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (old_atom)
    );

    cbp_dist_unit u_dist (
        .clk      (clk),
        .ctrl     (dp_ctrl),
        .new_atom (atom_reg),
        .old_atom (old_atom),
        .tol      (tol_reg),
        .in_reach (in_reach)
    );

    cbp_ctrl #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_start     (s_tuser),
        .in_reach     (in_reach),
        .dp_ctrl      (dp_ctrl),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_earlier  (out_earlier),
        .out_new      (out_new),
        .out_bonded   (out_bonded),
        .out_overflow (out_overflow),
        .out_last     (m_tlast)
    );

    assign m_tdata = {4'b0, out_new, out_earlier};
    assign m_tuser = {out_overflow, out_bonded};

endmodule
`default_nettype wire

/* tb/sv/tb_covalent_bond_perception.sv */
// ----------------------------------------------------------------------------
// tb_covalent_bond_perception
// Self-checking bench for the covalent bond perception block. Atoms stream in
// and every bond pair, empty search and overflow result is checked against a
// bench-side bond search. The stream has random idle gaps on both sides and
// one long result stall. The bond tolerance is changed over APB between phases.
// ----------------------------------------------------------------------------
module tb_covalent_bond_perception;

    localparam int      MAX_ATOMS    = cbp_pkg::MAX_ATOMS_DEF;
    localparam int      CW           = cbp_pkg::COORD_W;
    localparam int      RW           = cbp_pkg::RAD_W;
    localparam int      TW           = cbp_pkg::TOL_W;
    localparam int      IW           = cbp_pkg::IDX_W;
    localparam int      AW           = cbp_pkg::APB_AW;
    localparam int      PHASE_ATOMS  = 84;
    localparam int      BIG_MOLECULE = 68;        // more atoms than the store holds
    localparam int      STALL_AT     = 60;        // atoms sent before the long result stall
    localparam int      STALL_CYCLES = 400;
    localparam int      DRAIN_CYCLES = 20;
    localparam int      END_SETTLE   = 32;
    localparam longint  CYCLE_LIMIT  = 10_000_000;
    localparam int      COORD_MIN    = -(1 << (CW - 1));
    localparam int      COORD_MAX    = (1 << (CW - 1)) - 1;
    localparam int      RAD_MAX      = (1 << RW) - 1;
    localparam int      TOL_MAX      = (1 << TW) - 1;
    localparam logic [AW-1:0] TOL_ADDR = AW'(4 * int'(cbp_pkg::REG_TOL));
    // common covalent radii (H, C, N, O, S, Cl, P, B, Br) in 1/1024 A
    localparam int      RADII [9]    = '{317, 778, 727, 676, 1075, 1044, 1137, 864, 1229};

    typedef struct packed {
        logic           start;
        cbp_pkg::atom_t pos;
    } atom_req_t;

    typedef struct packed {
        logic [IW-1:0] earlier;
        logic [IW-1:0] newer;
        logic          bonded;
        logic          overflow;
        logic          last;
    } bond_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [AW-1:0]      paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [71:0]        s_tdata  = '0;     // coord_x, coord_y, coord_z, atom_radius
    logic               s_tuser  = 1'b0;   // start_molecule
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [15:0]        m_tdata;           // earlier_index, new_index, 4'b0
    logic [1:0]         m_tuser;           // bonded, overflow
    logic               m_tlast;           // last_result

    // bench-side copy of the molecule store and the tolerance register
    cbp_pkg::atom_t     mol_atoms [MAX_ATOMS];
    int                 mol_count    = 0;
    logic [TW-1:0]      tol_now      = cbp_pkg::TOL_RESET;

    atom_req_t          atom_backlog [$];
    bond_t              pending_bonds [$];

    longint             cycle_count  = 0;
    int                 atoms_sent   = 0;
    int                 results_seen = 0;
    int                 bonds_seen   = 0;
    int                 overflows    = 0;
    int                 errors       = 0;
    int                 tol_settings = 1;
    int                 stall_left   = 0;
    bit                 stall_fired  = 1'b0;
    bit                 quiet;

    covalent_bond_perception DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    // quiet windows give stretches with no idling on either side
    assign quiet = (cycle_count % 1024) < 200;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clamp_coord(int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic void expect_result(bond_t b);
        pending_bonds.insert(pending_bonds.size(), b);
    endfunction

    function automatic void add_request(atom_req_t a);
        atom_backlog.insert(atom_backlog.size(), a);
    endfunction

    // Bond search for one accepted atom; queues the results it must cause.
    function automatic void predict_bonds(atom_req_t a);
        longint dx, dy, dz, d2, lim;
        int     idx;
        int     found;
        bond_t  prev;
        if (a.start)
            mol_count = 0;
        if (mol_count >= MAX_ATOMS)
        begin
            expect_result('{earlier: '0, newer: '0, bonded: 1'b0,
                            overflow: 1'b1, last: 1'b1});
            return;
        end
        idx   = mol_count;
        found = 0;
        for (int i = 0; i < idx; i++)
        begin
            dx  = longint'(a.pos.x) - longint'(mol_atoms[i].x);
            dy  = longint'(a.pos.y) - longint'(mol_atoms[i].y);
            dz  = longint'(a.pos.z) - longint'(mol_atoms[i].z);
            d2  = dx * dx + dy * dy + dz * dz;
            lim = longint'(a.pos.r) + longint'(mol_atoms[i].r) + longint'(tol_now);
            if (d2 <= lim * lim && found < cbp_pkg::MAX_RESULTS)
            begin
                // hold back the latest pair so the final one can carry last
                if (found > 0)
                    expect_result(prev);
                prev = '{earlier: IW'(i), newer: IW'(idx), bonded: 1'b1,
                         overflow: 1'b0, last: 1'b0};
                found++;
            end
        end
        if (found == 0)
        begin
            expect_result('{earlier: '0, newer: IW'(idx), bonded: 1'b0,
                            overflow: 1'b0, last: 1'b1});
        end
        else
        begin
            prev.last = 1'b1;
            expect_result(prev);
        end
        mol_atoms[idx] = a.pos;
        mol_count      = idx + 1;
    endfunction

    // atom source
    always @(posedge clk)
    begin : atom_driver
        atom_req_t cur;
        int        send_gap;
        bit        accepted;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            accepted = s_tvalid && s_tready;
            if (accepted)
            begin
                predict_bonds(cur);
                atoms_sent++;
                send_gap = pick_gap();
            end
            if (s_tvalid && !accepted)
            begin
                // keep offering the same atom
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (atom_backlog.size() > 0)
            begin
                cur = atom_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= cur.pos;
                s_tuser  <= cur.start;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // one long result stall, so the block backs up into its input
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
        end
        else if (!stall_fired && atoms_sent >= STALL_AT)
        begin
            stall_left  <= STALL_CYCLES;
            stall_fired <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    // result checker
    always @(posedge clk)
    begin : result_monitor
        bond_t seen, want;
        int    rcv_gap;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rcv_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.earlier  = m_tdata[IW-1:0];
                seen.newer    = m_tdata[2*IW-1:IW];
                seen.bonded   = m_tuser[0];
                seen.overflow = m_tuser[1];
                seen.last     = m_tlast;
                results_seen++;
                bonds_seen += seen.bonded;
                overflows  += seen.overflow;
                if (pending_bonds.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"ERROR: unexpected result earlier=%0d new=%0d",
                                  " bonded=%0d ovf=%0d last=%0d"},
                                 seen.earlier, seen.newer, seen.bonded,
                                 seen.overflow, seen.last);
                end
                else
                begin
                    want = pending_bonds.pop_front();
                    if (seen != want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"ERROR: result %0d exp e=%0d n=%0d b=%0d o=%0d l=%0d",
                                      " got e=%0d n=%0d b=%0d o=%0d l=%0d"},
                                     results_seen, want.earlier, want.newer,
                                     want.bonded, want.overflow, want.last,
                                     seen.earlier, seen.newer, seen.bonded,
                                     seen.overflow, seen.last);
                    end
                end
                rcv_gap = pick_gap();
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
            end
            else if (rcv_gap > 0)
            begin
                rcv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_bonds.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_atom(input bit start, input int x, input int y, input int z,
                             input int r);
        atom_req_t a;
        a.start = start;
        a.pos.x = CW'(x);
        a.pos.y = CW'(y);
        a.pos.z = CW'(z);
        a.pos.r = RW'(r);
        add_request(a);
    endtask

    task automatic apb_write(input logic [AW-1:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_tolerance(input int tol, input bit junk_upper);
        logic [31:0] word;
        word = 32'(tol);
        if (junk_upper)
            word[31:TW] = (32 - TW)'($urandom());
        apb_write(TOL_ADDR, word);
        tol_now = TW'(tol);
        tol_settings++;
    endtask

    task automatic wait_idle();
        while (atom_backlog.size() > 0 || s_tvalid || pending_bonds.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One molecule: mostly atoms placed near an earlier one, some right on the
    // bond limit, some anywhere; now and then a start flag goes missing or
    // shows up mid-molecule, unless the molecule is solid.
    task automatic queue_molecule(input int n_atoms, input bit solid);
        cbp_pkg::atom_t placed [$];
        cbp_pkg::atom_t a;
        cbp_pkg::atom_t ref_atom;
        int             roll, off, lim, axis;
        bit             start;
        for (int k = 0; k < n_atoms; k++)
        begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 80)
                a.r = RW'(RADII[$urandom_range(0, 8)]);
            else
                a.r = RW'($urandom_range(0, RAD_MAX));
            if (k == 0 || roll < 10)
            begin
                a.x = CW'($urandom());
                a.y = CW'($urandom());
                a.z = CW'($urandom());
            end
            else
            begin
                ref_atom = placed[$urandom_range(0, placed.size() - 1)];
                a.x = ref_atom.x;
                a.y = ref_atom.y;
                a.z = ref_atom.z;
                if (roll < 25)
                begin
                    lim  = int'(a.r) + int'(ref_atom.r) + int'(tol_now);
                    off  = lim + int'($urandom_range(0, 2)) - 1;
                    off  = ($urandom_range(0, 1) != 0) ? off : -off;
                    axis = $urandom_range(0, 2);
                    if (axis == 0)
                        a.x = CW'(clamp_coord(int'(ref_atom.x) + off));
                    else if (axis == 1)
                        a.y = CW'(clamp_coord(int'(ref_atom.y) + off));
                    else
                        a.z = CW'(clamp_coord(int'(ref_atom.z) + off));
                end
                else
                begin
                    a.x = CW'(clamp_coord(int'(ref_atom.x)
                                          + int'($urandom_range(0, 3200)) - 1600));
                    a.y = CW'(clamp_coord(int'(ref_atom.y)
                                          + int'($urandom_range(0, 3200)) - 1600));
                    a.z = CW'(clamp_coord(int'(ref_atom.z)
                                          + int'($urandom_range(0, 3200)) - 1600));
                end
            end
            if (solid)
                start = (k == 0);
            else if (k == 0)
                start = ($urandom_range(0, 99) < 95);
            else
                start = ($urandom_range(0, 99) < 3);
            placed.insert(placed.size(), a);
            add_request('{start: start, pos: a});
        end
    endtask

    initial
    begin : stimulus
        int phase_tol [4];
        int phase_atoms;
        phase_tol = '{TOL_MAX, 0, $urandom_range(1, TOL_MAX - 1),
                      int'(cbp_pkg::TOL_RESET)};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset tolerance
        push_atom(0, 0, 0, 0, 700);                               // first atom, nothing stored
        push_atom(0, 1400, 0, 0, 700);                            // plain bond
        push_atom(0, 0, -1461, 0, 300);                           // exactly on the limit
        push_atom(0, 0, 0, 1462, 300);                            // one unit past the limit
        push_atom(0, COORD_MAX, COORD_MIN, COORD_MAX, RAD_MAX);   // far corner
        push_atom(0, COORD_MIN, COORD_MAX, COORD_MIN, RAD_MAX);   // opposite corner
        push_atom(0, COORD_MAX, COORD_MIN, COORD_MAX, 0);         // on top of a corner atom
        push_atom(1, 0, 0, 0, 0);                                 // new molecule clears store
        push_atom(0, 0, 0, 0, 0);                                 // coincident, zero radii
        push_atom(0, 0, 0, 0, 0);
        push_atom(0, 0, 0, 0, 0);
        push_atom(0, 200, -200, 100, RAD_MAX);                    // bonds with every atom so far
        push_atom(0, -461, 0, 0, 0);
        push_atom(0, 0, 0, -462, 0);
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            set_tolerance(phase_tol[p], p == 2);
            phase_atoms = 0;
            if (p == 1)
            begin
                queue_molecule(BIG_MOLECULE, 1'b1);
                phase_atoms = BIG_MOLECULE;
            end
            while (phase_atoms < PHASE_ATOMS)
            begin
                int n;
                n = ($urandom_range(0, 99) < 80) ? $urandom_range(2, 12)
                                                 : $urandom_range(13, 40);
                queue_molecule(n, 1'b0);
                phase_atoms += n;
            end
            wait_idle();
        end

        repeat (END_SETTLE) @(posedge clk);
        errors += pending_bonds.size();
        $display("sent %0d atoms under %0d tolerance settings, %0d results checked",
                 atoms_sent, tol_settings, results_seen);
        $display("%0d bond pairs, %0d overflow drops, %0d mismatches",
                 bonds_seen, overflows, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* covalent_bond_perception.f */
rtl/cbp_pkg.sv
rtl/cbp_atom_mem.sv
rtl/cbp_dist_unit.sv
rtl/cbp_ctrl.sv
rtl/covalent_bond_perception.sv
tb/sv/tb_covalent_bond_perception.sv
